>>> src/tcc_pkg.sv
// Shared types and constants for the triangle circumcircle pipeline.
package tcc_pkg;

    // Divider row: one quotient bit per cell, 41 bits cover offsets up to 2^40
    localparam int DIV_BITS = 41;
    localparam int DEN_W    = 35;
    localparam int NUM_W    = 68;

    // Root row: one result bit per cell over a 64-bit squared distance
    localparam int ROOT_W  = 32;
    localparam int RAD_W   = 64;
    localparam int SQREM_W = 34;

    // Offset cap of the circumcenter from vertex A, in Q16.16 LSB
    localparam logic [DIV_BITS-1:0] OFF_CAP = 41'h100_0000_0000;

    // Centroid divides the coordinate sum by three
    localparam logic [DEN_W-1:0] CENTROID_DEN = 35'd3;

    localparam logic [15:0] THRESH_RESET = 16'd7;

    typedef struct packed {
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] x2;
        logic signed [15:0] y2;
        logic signed [15:0] x3;
        logic signed [15:0] y3;
    } coord_t;

    typedef struct packed {
        logic [DEN_W-1:0]    rem;
        logic [DEN_W-1:0]    den;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] quo;
        logic                ovf;
    } div_lane_t;

    typedef struct packed {
        logic [RAD_W-1:0]   rad;
        logic [SQREM_W-1:0] rem;
        logic [ROOT_W-1:0]  root;
    } sqrt_lane_t;

    typedef struct packed {
        logic   col;
        logic   neg_x;
        logic   neg_y;
        coord_t crd;
    } div_side_t;

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic        col;
        logic        sat;
    } root_side_t;

endpackage

>>> src/tcc_in_if.sv
// Input channel: one triangle item, three signed vertices.
interface tcc_in_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] ccx;
    logic signed [COORD_WIDTH-1:0] ccy;

    modport source (output valid, output ax, output ay, output bx, output by,
                    output ccx, output ccy, input ready);
    modport sink   (input valid, input ax, input ay, input bx, input by,
                    input ccx, input ccy, output ready);
endinterface

>>> src/tcc_out_if.sv
// Output channel: one circle item, center, radius and flags.
interface tcc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [31:0]        circle_radius;
    logic               collinear;
    logic               saturated;

    modport source (output valid, output center_x, output center_y, output circle_radius,
                    output collinear, output saturated, input ready);
    modport sink   (input valid, input center_x, input center_y, input circle_radius,
                    input collinear, input saturated, output ready);
endinterface

>>> src/tcc_div_cell.sv
// Divider cell: one restoring quotient bit per cycle while en is high, handed to the next cell.
module tcc_div_cell (
    input  logic                clk,
    input  logic                en,
    input  tcc_pkg::div_lane_t  lane_in,
    output tcc_pkg::div_lane_t  lane_out
);

    logic [tcc_pkg::DEN_W:0] trial;
    logic [tcc_pkg::DEN_W:0] diff;
    logic                    fits;
    tcc_pkg::div_lane_t      lane_next;
    tcc_pkg::div_lane_t      lane_reg;

    // Bring down one numerator bit and try the subtract
    always_comb
    begin
        trial     = {lane_in.rem, lane_in.num[tcc_pkg::DIV_BITS-1]};
        diff      = trial - {1'b0, lane_in.den};
        fits      = trial >= {1'b0, lane_in.den};
        lane_next = lane_in;
        lane_next.rem = fits ? diff[tcc_pkg::DEN_W-1:0] : trial[tcc_pkg::DEN_W-1:0];
        lane_next.num = {lane_in.num[tcc_pkg::DIV_BITS-2:0], 1'b0};
        lane_next.quo = {lane_in.quo[tcc_pkg::DIV_BITS-2:0], fits};
    end

    // Advance with the row
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

>>> src/tcc_sqrt_cell.sv
// Root cell: one square root bit per cycle while en is high, handed to the next cell.
module tcc_sqrt_cell (
    input  logic                clk,
    input  logic                en,
    input  tcc_pkg::sqrt_lane_t lane_in,
    output tcc_pkg::sqrt_lane_t lane_out
);

    logic [tcc_pkg::SQREM_W+1:0] trial;
    logic [tcc_pkg::SQREM_W+1:0] probe;
    logic [tcc_pkg::SQREM_W+1:0] diff;
    logic                        fits;
    tcc_pkg::sqrt_lane_t         lane_next;
    tcc_pkg::sqrt_lane_t         lane_reg;

    // Bring down two radicand bits and test root*4+1
    always_comb
    begin
        trial     = {lane_in.rem, lane_in.rad[tcc_pkg::RAD_W-1:tcc_pkg::RAD_W-2]};
        probe     = {2'b00, lane_in.root, 2'b01};
        diff      = trial - probe;
        fits      = trial >= probe;
        lane_next = lane_in;
        lane_next.rem  = fits ? diff[tcc_pkg::SQREM_W-1:0] : trial[tcc_pkg::SQREM_W-1:0];
        lane_next.rad  = {lane_in.rad[tcc_pkg::RAD_W-3:0], 2'b00};
        lane_next.root = {lane_in.root[tcc_pkg::ROOT_W-2:0], fits};
    end

    // Advance with the row
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

>>> src/triangle_circumcircle_core.sv
// Top level: circumcircle of a triangle with centroid fallback, fully pipelined.
//
//  channel     dir  handshake          payload
//  tri_in      in   valid / ready      ax ay bx by ccx ccy (signed, COORD_FRAC frac bits)
//  circle_out  out  valid / ready      center_x center_y circle_radius collinear saturated
//  cfg         in   cfg_wr_en          cfg_wr_data = collinear threshold
//
// One triangle per cycle; six front stages, a row of 41
// divider cells, five middle stages, a row of 32 root cells, the output register.
// All stages advance together; a result waiting on circle_out holds the row and
// drops tri_in.ready, otherwise items enter every cycle.
// Reset clears the valid bits and loads the threshold with 7.
module triangle_circumcircle_core #(
    parameter int COORD_WIDTH = 16,
    parameter int COORD_FRAC  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    tcc_in_if.sink      tri_in,
    tcc_out_if.source   circle_out
);

    localparam int IN_BITS  = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
    localparam int UP_SHIFT = (COORD_FRAC > 16) ? 0 : 16 - COORD_FRAC;
    localparam int DIV_OUT  = 5 + tcc_pkg::DIV_BITS;
    localparam int PIPE     = 6 + tcc_pkg::DIV_BITS + 5 + tcc_pkg::ROOT_W + 1;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] scale(logic signed [15:0] v);
        logic signed [31:0] w;
        w     = 32'(v);
        scale = w <<< UP_SHIFT;
    endfunction

    function automatic logic [41:0] off_mag(tcc_pkg::div_lane_t l, logic col);
        logic [35:0] twice;
        logic        up;
        logic [41:0] v;
        twice = {l.rem, 1'b0};
        up    = twice >= {1'b0, l.den};
        v     = {1'b0, l.quo} + {41'b0, up};
        if (col)
            off_mag = {1'b0, l.quo};
        else if (l.ovf || (v > {1'b0, tcc_pkg::OFF_CAP}))
            off_mag = {1'b0, tcc_pkg::OFF_CAP};
        else
            off_mag = v;
    endfunction

    function automatic logic [40:0] mag41(logic signed [43:0] v);
        logic [43:0] a;
        a     = v[43] ? 44'(-v) : 44'(v);
        mag41 = a[40:0];
    endfunction

    // {clipped flag, value}
    function automatic logic [32:0] clip32(logic signed [43:0] v);
        if (v > 44'sd2147483647)
            clip32 = {1'b1, 32'h7FFF_FFFF};
        else if (v < -44'sd2147483648)
            clip32 = {1'b1, 32'h8000_0000};
        else
            clip32 = {1'b0, v[31:0]};
    endfunction

    function automatic logic [63:0] sq_sat(logic [40:0] m);
        logic [31:0] a;
        logic [63:0] p;
        a = m[31:0];
        p = a * a;
        sq_sat = (m[40:32] != '0) ? '1 : p;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        add_sat = s[64] ? '1 : s[63:0];
    endfunction

    // ------------------------------------------------------------------
    // Control: global advance, valid shift line, threshold register
    // ------------------------------------------------------------------
    logic            adv;
    logic [PIPE-1:0] vld_reg;
    logic [15:0]     thr_reg;

    assign adv          = !vld_reg[PIPE-1] || circle_out.ready;
    assign tri_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            thr_reg <= tcc_pkg::THRESH_RESET;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[PIPE-2:0], tri_in.valid};
            end
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: capture vertices
    // ------------------------------------------------------------------
    tcc_pkg::coord_t crd_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            crd_a_reg.x1 <= 16'($signed(tri_in.ax[IN_BITS-1:0]));
            crd_a_reg.y1 <= 16'($signed(tri_in.ay[IN_BITS-1:0]));
            crd_a_reg.x2 <= 16'($signed(tri_in.bx[IN_BITS-1:0]));
            crd_a_reg.y2 <= 16'($signed(tri_in.by[IN_BITS-1:0]));
            crd_a_reg.x3 <= 16'($signed(tri_in.ccx[IN_BITS-1:0]));
            crd_a_reg.y3 <= 16'($signed(tri_in.ccy[IN_BITS-1:0]));
        end
    end

    // ------------------------------------------------------------------
    // Stage B: edge vectors and coordinate sums
    // ------------------------------------------------------------------
    logic signed [16:0] ex_b_reg, ey_b_reg, fx_b_reg, fy_b_reg;
    logic signed [17:0] sumx_b_reg, sumy_b_reg;
    tcc_pkg::coord_t    crd_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_b_reg   <= 17'($signed(crd_a_reg.x2)) - 17'($signed(crd_a_reg.x1));
            ey_b_reg   <= 17'($signed(crd_a_reg.y2)) - 17'($signed(crd_a_reg.y1));
            fx_b_reg   <= 17'($signed(crd_a_reg.x3)) - 17'($signed(crd_a_reg.x1));
            fy_b_reg   <= 17'($signed(crd_a_reg.y3)) - 17'($signed(crd_a_reg.y1));
            sumx_b_reg <= 18'($signed(crd_a_reg.x1)) + 18'($signed(crd_a_reg.x2))
                          + 18'($signed(crd_a_reg.x3));
            sumy_b_reg <= 18'($signed(crd_a_reg.y1)) + 18'($signed(crd_a_reg.y2))
                          + 18'($signed(crd_a_reg.y3));
            crd_b_reg  <= crd_a_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: cross products and squares
    // ------------------------------------------------------------------
    logic signed [33:0] pd1_c_reg, pd2_c_reg;
    logic signed [33:0] sqex_c_reg, sqey_c_reg, sqfx_c_reg, sqfy_c_reg;
    logic signed [16:0] ex_c_reg, ey_c_reg, fx_c_reg, fy_c_reg;
    logic signed [17:0] sumx_c_reg, sumy_c_reg;
    tcc_pkg::coord_t    crd_c_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pd1_c_reg  <= ex_b_reg * fy_b_reg;
            pd2_c_reg  <= fx_b_reg * ey_b_reg;
            sqex_c_reg <= ex_b_reg * ex_b_reg;
            sqey_c_reg <= ey_b_reg * ey_b_reg;
            sqfx_c_reg <= fx_b_reg * fx_b_reg;
            sqfy_c_reg <= fy_b_reg * fy_b_reg;
            ex_c_reg   <= ex_b_reg;
            ey_c_reg   <= ey_b_reg;
            fx_c_reg   <= fx_b_reg;
            fy_c_reg   <= fy_b_reg;
            sumx_c_reg <= sumx_b_reg;
            sumy_c_reg <= sumy_b_reg;
            crd_c_reg  <= crd_b_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: determinant and squared edge lengths
    // ------------------------------------------------------------------
    logic signed [34:0] ddiff;
    logic signed [35:0] d_d_reg;
    logic signed [34:0] e2_d_reg, f2_d_reg;
    logic signed [16:0] ex_d_reg, ey_d_reg, fx_d_reg, fy_d_reg;
    logic signed [17:0] sumx_d_reg, sumy_d_reg;
    tcc_pkg::coord_t    crd_d_reg;

    assign ddiff = 35'(pd1_c_reg) - 35'(pd2_c_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_d_reg    <= {ddiff, 1'b0};
            e2_d_reg   <= 35'(sqex_c_reg) + 35'(sqey_c_reg);
            f2_d_reg   <= 35'(sqfx_c_reg) + 35'(sqfy_c_reg);
            ex_d_reg   <= ex_c_reg;
            ey_d_reg   <= ey_c_reg;
            fx_d_reg   <= fx_c_reg;
            fy_d_reg   <= fy_c_reg;
            sumx_d_reg <= sumx_c_reg;
            sumy_d_reg <= sumy_c_reg;
            crd_d_reg  <= crd_c_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: center numerator products, |D| and collinear decision
    // ------------------------------------------------------------------
    logic [35:0]        dabs;
    logic [34:0]        dm_next;
    logic               col_next;
    logic signed [51:0] pnx1_e_reg, pnx2_e_reg, pny1_e_reg, pny2_e_reg;
    logic [34:0]        dm_e_reg;
    logic               dneg_e_reg;
    logic               col_e_reg;
    logic signed [17:0] sumx_e_reg, sumy_e_reg;
    tcc_pkg::coord_t    crd_e_reg;

    always_comb
    begin
        dabs     = d_d_reg[35] ? 36'(-d_d_reg) : 36'(d_d_reg);
        dm_next  = dabs[34:0];
        col_next = (d_d_reg == '0) || (dm_next < {19'b0, thr_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pnx1_e_reg <= fy_d_reg * e2_d_reg;
            pnx2_e_reg <= ey_d_reg * f2_d_reg;
            pny1_e_reg <= ex_d_reg * f2_d_reg;
            pny2_e_reg <= fx_d_reg * e2_d_reg;
            dm_e_reg   <= dm_next;
            dneg_e_reg <= d_d_reg[35];
            col_e_reg  <= col_next;
            sumx_e_reg <= sumx_d_reg;
            sumy_e_reg <= sumy_d_reg;
            crd_e_reg  <= crd_d_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: load the divider lanes
    // ------------------------------------------------------------------
    logic signed [52:0] nx, ny;
    logic [52:0]        nxa, nya;
    logic signed [33:0] sx, sy;
    logic [33:0]        sxa, sya;
    logic [67:0]        numx, numy;
    logic [34:0]        den;
    logic [34:0]        headx, heady;
    logic               ovfx, ovfy;
    tcc_pkg::div_lane_t divx_next, divy_next, divx_f_reg, divy_f_reg;
    tcc_pkg::div_side_t side_next, side_f_reg;

    always_comb
    begin
        nx   = 53'(pnx1_e_reg) - 53'(pnx2_e_reg);
        ny   = 53'(pny1_e_reg) - 53'(pny2_e_reg);
        nxa  = nx[52] ? 53'(-nx) : 53'(nx);
        nya  = ny[52] ? 53'(-ny) : 53'(ny);
        sx   = 34'(sumx_e_reg) <<< UP_SHIFT;
        sy   = 34'(sumy_e_reg) <<< UP_SHIFT;
        sxa  = sx[33] ? 34'(-sx) : 34'(sx);
        sya  = sy[33] ? 34'(-sy) : 34'(sy);
        numx = col_e_reg ? ({34'b0, sxa} + 68'd1) : ({16'b0, nxa[51:0]} << UP_SHIFT);
        numy = col_e_reg ? ({34'b0, sya} + 68'd1) : ({16'b0, nya[51:0]} << UP_SHIFT);
        den  = col_e_reg ? tcc_pkg::CENTROID_DEN : dm_e_reg;

        // Quotient would need more than 41 bits: hold at the cap later
        headx = {8'b0, numx[67:41]};
        heady = {8'b0, numy[67:41]};
        ovfx  = headx >= den;
        ovfy  = heady >= den;

        divx_next.rem = ovfx ? '0 : headx;
        divx_next.den = den;
        divx_next.num = numx[40:0];
        divx_next.quo = '0;
        divx_next.ovf = ovfx;
        divy_next.rem = ovfy ? '0 : heady;
        divy_next.den = den;
        divy_next.num = numy[40:0];
        divy_next.quo = '0;
        divy_next.ovf = ovfy;

        side_next.col   = col_e_reg;
        side_next.neg_x = col_e_reg ? sx[33] : (nx[52] ^ dneg_e_reg);
        side_next.neg_y = col_e_reg ? sy[33] : (ny[52] ^ dneg_e_reg);
        side_next.crd   = crd_e_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            divx_f_reg <= divx_next;
            divy_f_reg <= divy_next;
            side_f_reg <= side_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider rows and their side line
    // ------------------------------------------------------------------
    tcc_pkg::div_lane_t divx_chain [tcc_pkg::DIV_BITS+1];
    tcc_pkg::div_lane_t divy_chain [tcc_pkg::DIV_BITS+1];
    tcc_pkg::div_side_t side_line_reg [tcc_pkg::DIV_BITS];

    assign divx_chain[0] = divx_f_reg;
    assign divy_chain[0] = divy_f_reg;

    for (genvar i = 0; i < tcc_pkg::DIV_BITS; i++)
    begin : g_div
        tcc_div_cell u_divx (
            .clk      (clk),
            .en       (adv),
            .lane_in  (divx_chain[i]),
            .lane_out (divx_chain[i+1])
        );
        tcc_div_cell u_divy (
            .clk      (clk),
            .en       (adv),
            .lane_in  (divy_chain[i]),
            .lane_out (divy_chain[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_line_reg[0] <= side_f_reg;
            for (int i = 1; i < tcc_pkg::DIV_BITS; i++)
            begin
                side_line_reg[i] <= side_line_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage G: round, cap and sign the offsets
    // ------------------------------------------------------------------
    tcc_pkg::div_side_t side_g;
    logic [41:0]        magx, magy;
    logic signed [42:0] ox_g_reg, oy_g_reg;
    logic               col_g_reg;
    tcc_pkg::coord_t    crd_g_reg;

    assign side_g = side_line_reg[tcc_pkg::DIV_BITS-1];
    assign magx   = off_mag(divx_chain[tcc_pkg::DIV_BITS], side_g.col);
    assign magy   = off_mag(divy_chain[tcc_pkg::DIV_BITS], side_g.col);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox_g_reg  <= side_g.neg_x ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
            oy_g_reg  <= side_g.neg_y ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
            col_g_reg <= side_g.col;
            crd_g_reg <= side_g.crd;
        end
    end

    // ------------------------------------------------------------------
    // Stage H: center, clipping and per-vertex offsets
    // ------------------------------------------------------------------
    logic signed [43:0] cenx, ceny;
    logic signed [43:0] dx1, dy1, dx2, dy2, dx3, dy3;
    logic [32:0]        clpx, clpy;
    tcc_pkg::root_side_t rs_h_next, rs_h_reg;
    logic [40:0]        mag_h_reg [6];

    always_comb
    begin
        if (col_g_reg)
        begin
            cenx = 44'(ox_g_reg);
            ceny = 44'(oy_g_reg);
            dx1  = 44'(scale(crd_g_reg.x1)) - 44'(ox_g_reg);
            dy1  = 44'(scale(crd_g_reg.y1)) - 44'(oy_g_reg);
            dx2  = 44'(scale(crd_g_reg.x2)) - 44'(ox_g_reg);
            dy2  = 44'(scale(crd_g_reg.y2)) - 44'(oy_g_reg);
            dx3  = 44'(scale(crd_g_reg.x3)) - 44'(ox_g_reg);
            dy3  = 44'(scale(crd_g_reg.y3)) - 44'(oy_g_reg);
        end
        else
        begin
            cenx = 44'(scale(crd_g_reg.x1)) + 44'(ox_g_reg);
            ceny = 44'(scale(crd_g_reg.y1)) + 44'(oy_g_reg);
            dx1  = 44'(ox_g_reg);
            dy1  = 44'(oy_g_reg);
            dx2  = '0;
            dy2  = '0;
            dx3  = '0;
            dy3  = '0;
        end
        clpx          = clip32(cenx);
        clpy          = clip32(ceny);
        rs_h_next.cx  = clpx[31:0];
        rs_h_next.cy  = clpy[31:0];
        rs_h_next.col = col_g_reg;
        rs_h_next.sat = clpx[32] | clpy[32];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs_h_reg     <= rs_h_next;
            mag_h_reg[0] <= mag41(dx1);
            mag_h_reg[1] <= mag41(dy1);
            mag_h_reg[2] <= mag41(dx2);
            mag_h_reg[3] <= mag41(dy2);
            mag_h_reg[4] <= mag41(dx3);
            mag_h_reg[5] <= mag41(dy3);
        end
    end

    // ------------------------------------------------------------------
    // Stage I: squares; stage J: squared distances; stage K: farthest
    // ------------------------------------------------------------------
    logic [63:0]         sq_i_reg [6];
    logic [63:0]         dist_j_reg [3];
    logic [63:0]         far12;
    tcc_pkg::root_side_t rs_i_reg, rs_j_reg, rs_k_reg;
    tcc_pkg::sqrt_lane_t root_k_reg;

    assign far12 = (dist_j_reg[0] > dist_j_reg[1]) ? dist_j_reg[0] : dist_j_reg[1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 6; i++)
            begin
                sq_i_reg[i] <= sq_sat(mag_h_reg[i]);
            end
            for (int i = 0; i < 3; i++)
            begin
                dist_j_reg[i] <= add_sat(sq_i_reg[2*i], sq_i_reg[2*i+1]);
            end
            root_k_reg.rad  <= (dist_j_reg[2] > far12) ? dist_j_reg[2] : far12;
            root_k_reg.rem  <= '0;
            root_k_reg.root <= '0;
            rs_i_reg <= rs_h_reg;
            rs_j_reg <= rs_i_reg;
            rs_k_reg <= rs_j_reg;
        end
    end

    // ------------------------------------------------------------------
    // Root row and its side line
    // ------------------------------------------------------------------
    tcc_pkg::sqrt_lane_t root_chain [tcc_pkg::ROOT_W+1];
    tcc_pkg::root_side_t rs_line_reg [tcc_pkg::ROOT_W];

    assign root_chain[0] = root_k_reg;

    for (genvar i = 0; i < tcc_pkg::ROOT_W; i++)
    begin : g_root
        tcc_sqrt_cell u_root (
            .clk      (clk),
            .en       (adv),
            .lane_in  (root_chain[i]),
            .lane_out (root_chain[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs_line_reg[0] <= rs_k_reg;
            for (int i = 1; i < tcc_pkg::ROOT_W; i++)
            begin
                rs_line_reg[i] <= rs_line_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: round the root, clip, flag
    // ------------------------------------------------------------------
    tcc_pkg::sqrt_lane_t root_o;
    tcc_pkg::root_side_t rs_o;
    logic                bump;
    logic [32:0]         rr;
    logic [31:0]         cx_o_reg, cy_o_reg, rad_o_reg;
    logic                col_o_reg, sat_o_reg;

    always_comb
    begin
        root_o = root_chain[tcc_pkg::ROOT_W];
        rs_o   = rs_line_reg[tcc_pkg::ROOT_W-1];
        bump   = root_o.rem > {2'b00, root_o.root};
        rr     = {1'b0, root_o.root} + {32'b0, bump};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_o_reg  <= rs_o.cx;
            cy_o_reg  <= rs_o.cy;
            rad_o_reg <= rr[32] ? '1 : rr[31:0];
            col_o_reg <= rs_o.col;
            sat_o_reg <= rs_o.sat | rr[32];
        end
    end

    assign circle_out.valid         = vld_reg[PIPE-1];
    assign circle_out.center_x      = cx_o_reg;
    assign circle_out.center_y      = cy_o_reg;
    assign circle_out.circle_radius = rad_o_reg;
    assign circle_out.collinear     = col_o_reg;
    assign circle_out.saturated     = sat_o_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        circle_out.valid && !circle_out.ready |-> !tri_in.ready)
        else $error("input taken while a result is held");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        tri_in.valid && tri_in.ready |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    a_offset_capped: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_OUT] && !side_g.col |->
            (magx <= {1'b0, tcc_pkg::OFF_CAP}) && (magy <= {1'b0, tcc_pkg::OFF_CAP}))
        else $error("circumcenter offset above cap");

    a_sat_means_clip: assert property (@(posedge clk) disable iff (!rst_n)
        circle_out.valid && circle_out.saturated |->
            (cx_o_reg == 32'h7FFF_FFFF) || (cx_o_reg == 32'h8000_0000) ||
            (cy_o_reg == 32'h7FFF_FFFF) || (cy_o_reg == 32'h8000_0000) ||
            (rad_o_reg == 32'hFFFF_FFFF))
        else $error("saturated flag without a clipped value");

endmodule
